// ===== hw/rtl/hex_frame_joystick_decoder_defines.svh =====
// assertion macros shared by the checker
`ifndef HEX_FRAME_JOYSTICK_DECODER_DEFINES_SVH
`define HEX_FRAME_JOYSTICK_DECODER_DEFINES_SVH

// condition in the same cycle implies consequence
`define HFJD_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("hfjd check failed");

// condition implies consequence in the next cycle
`define HFJD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("hfjd check failed");

`endif

// ===== hw/rtl/hfjd_pkg.sv =====
package hfjd_pkg;

   localparam logic [7:0] START_CHAR_RESET = 8'd42;
   localparam logic [7:0] ASCII_ZERO       = 8'd48;
   localparam logic [7:0] ASCII_NINE       = 8'd57;
   localparam logic [7:0] ASCII_UPPER_A    = 8'd65;
   localparam logic [7:0] ASCII_UPPER_F    = 8'd70;
   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd55;

   localparam int POS_W = 4;
   // payload positions: 0..3 are X, 4..7 are Y, 8 is gear
   localparam logic [POS_W-1:0] X_END_POS  = 4'd4;
   localparam logic [POS_W-1:0] GEAR_POS   = 4'd8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one classified byte
   typedef struct packed {
      logic       is_start;
      logic       bad;
      logic [3:0] nib;
   } token_type;

endpackage

// ===== hw/rtl/hex_frame_joystick_decoder.sv =====
// a result is shown after the gear byte passes the byte queue and the output register
// throughput: one byte per cycle; the back end holds only on the gear byte while the
// output register is full and stalled, and the 2-entry byte queue then holds the gear
// byte and one more before the input stalls
// reset (synchronous, active high): start character back to 42, no open frame,
// byte queue empty, no result pending
module hex_frame_joystick_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_start_char,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_x_value,
   output logic signed [15:0] rsp_y_value,
   output logic [3:0]         rsp_gear,
   output logic               rsp_bad_char
);

   logic                q_full;
   logic                push;
   hfjd_pkg::token_type push_tok;
   logic                tok_valid;
   hfjd_pkg::token_type tok;
   logic                pop;

   hfjd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_start_char (csr_start_char),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .q_full         (q_full),
      .push           (push),
      .push_tok       (push_tok)
   );

   hfjd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tok  (push_tok),
      .full      (q_full),
      .tok_valid (tok_valid),
      .tok       (tok),
      .pop       (pop)
   );

   hfjd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tok_valid    (tok_valid),
      .tok          (tok),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_x_value  (rsp_x_value),
      .rsp_y_value  (rsp_y_value),
      .rsp_gear     (rsp_gear),
      .rsp_bad_char (rsp_bad_char)
   );

endmodule

// ===== hw/rtl/hfjd_queue.sv =====
module hfjd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hfjd_pkg::token_type push_tok,
   output logic                full,
   output logic                tok_valid,
   output hfjd_pkg::token_type tok,
   input  logic                pop
);

   hfjd_pkg::token_type                     mem [hfjd_pkg::QUEUE_DEPTH];
   logic [hfjd_pkg::QUEUE_AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [hfjd_pkg::QUEUE_AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [hfjd_pkg::QUEUE_CW-1:0]           count_ff, count_in;

   localparam logic [hfjd_pkg::QUEUE_AW-1:0] LAST_IDX =
      hfjd_pkg::QUEUE_AW'(hfjd_pkg::QUEUE_DEPTH - 1);
   localparam logic [hfjd_pkg::QUEUE_CW-1:0] FULL_COUNT =
      hfjd_pkg::QUEUE_CW'(hfjd_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == FULL_COUNT);
   assign tok_valid = (count_ff != '0);
   assign tok       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// ===== hw/rtl/hfjd_front.sv =====
module hfjd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_start_char,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                q_full,
   output logic                push,
   output hfjd_pkg::token_type push_tok
);

   logic [7:0] start_char_ff;
   logic [7:0] alpha_diff;
   logic       is_digit;
   logic       is_alpha;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= hfjd_pkg::START_CHAR_RESET;
      end else if (csr_valid && csr_ready) begin
         start_char_ff <= csr_start_char;
      end
   end

   assign is_digit   = (req_in_byte >= hfjd_pkg::ASCII_ZERO) &&
                       (req_in_byte <= hfjd_pkg::ASCII_NINE);
   assign is_alpha   = (req_in_byte >= hfjd_pkg::ASCII_UPPER_A) &&
                       (req_in_byte <= hfjd_pkg::ASCII_UPPER_F);
   assign alpha_diff = req_in_byte - hfjd_pkg::HEX_ALPHA_OFFSET;

   always_comb begin
      push_tok.is_start = (req_in_byte == start_char_ff);
      push_tok.bad      = !(is_digit || is_alpha);
      if (is_digit) begin
         // '0' is 0x30, so the low nibble is the value
         push_tok.nib = req_in_byte[3:0];
      end else if (is_alpha) begin
         push_tok.nib = alpha_diff[3:0];
      end else begin
         push_tok.nib = 4'd0;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

endmodule

// ===== hw/rtl/hfjd_back.sv =====
module hfjd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  hfjd_pkg::token_type tok,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_x_value,
   output logic signed [15:0]  rsp_y_value,
   output logic [3:0]          rsp_gear,
   output logic                rsp_bad_char
);

   logic                          in_frame_ff, in_frame_in;
   logic [hfjd_pkg::POS_W-1:0]    digit_pos_ff, digit_pos_in;
   logic [15:0]                   x_shift_ff, x_shift_in;
   logic [15:0]                   y_shift_ff, y_shift_in;
   logic                          error_seen_ff, error_seen_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_x_ff;
   logic [15:0]                   rsp_y_ff;
   logic [3:0]                    rsp_gear_ff;
   logic                          rsp_bad_ff;
   logic                          last_digit;
   logic                          emit;
   logic                          err_next;

   // gear digit (or anything past it) closes the frame
   assign last_digit = in_frame_ff && (digit_pos_ff >= hfjd_pkg::GEAR_POS);
   assign pop        = tok_valid && (!last_digit || !rsp_valid_ff || !rsp_stall);
   assign emit       = pop && last_digit;
   assign err_next   = error_seen_ff | tok.bad;

   always_comb begin
      in_frame_in   = in_frame_ff;
      digit_pos_in  = digit_pos_ff;
      x_shift_in    = x_shift_ff;
      y_shift_in    = y_shift_ff;
      error_seen_in = error_seen_ff;
      if (pop) begin
         if (!in_frame_ff) begin
            if (tok.is_start) begin
               in_frame_in   = 1'b1;
               digit_pos_in  = '0;
               x_shift_in    = '0;
               y_shift_in    = '0;
               error_seen_in = 1'b0;
            end
         end else if (digit_pos_ff < hfjd_pkg::X_END_POS) begin
            x_shift_in    = {x_shift_ff[11:0], tok.nib};
            digit_pos_in  = digit_pos_ff + 1'b1;
            error_seen_in = err_next;
         end else if (digit_pos_ff < hfjd_pkg::GEAR_POS) begin
            y_shift_in    = {y_shift_ff[11:0], tok.nib};
            digit_pos_in  = digit_pos_ff + 1'b1;
            error_seen_in = err_next;
         end else begin
            in_frame_in   = 1'b0;
            digit_pos_in  = '0;
            error_seen_in = err_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         digit_pos_ff  <= '0;
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         digit_pos_ff  <= digit_pos_in;
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_shift_ff <= x_shift_in;
      y_shift_ff <= y_shift_in;
      if (emit) begin
         rsp_x_ff    <= x_shift_ff;
         rsp_y_ff    <= y_shift_ff;
         rsp_gear_ff <= tok.nib;
         rsp_bad_ff  <= err_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_x_value  = $signed(rsp_x_ff);
   assign rsp_y_value  = $signed(rsp_y_ff);
   assign rsp_gear     = rsp_gear_ff;
   assign rsp_bad_char = rsp_bad_ff;

endmodule

// ===== hw/rtl/hfjd_checker.sv =====
`include "hex_frame_joystick_decoder_defines.svh"

module hfjd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_x_value,
   input logic signed [15:0] rsp_y_value,
   input logic [3:0]         rsp_gear,
   input logic               rsp_bad_char
);

   // queue and output register come out of reset empty
   `HFJD_ASSERT_NOW(a_no_rsp_after_reset, clock, 1'b0, $past(reset) && !reset, !rsp_valid)
   `HFJD_ASSERT_NOW(a_open_after_reset, clock, 1'b0, $past(reset) && !reset, !req_stall)
   // a stalled result stays until its transfer
   `HFJD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `HFJD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_x_value) && $stable(rsp_y_value) && $stable(rsp_gear) && $stable(rsp_bad_char))

endmodule

bind hex_frame_joystick_decoder hfjd_checker u_hfjd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_x_value  (rsp_x_value),
   .rsp_y_value  (rsp_y_value),
   .rsp_gear     (rsp_gear),
   .rsp_bad_char (rsp_bad_char)
);

// ===== test/hex_frame_joystick_decoder_test.sv =====
module hex_frame_joystick_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_LIMIT      = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int FRAMES_PER_PHASE = 13;
   localparam int PHASE_COUNT      = 4;

   typedef struct packed {
      logic [15:0] x_value;
      logic [15:0] y_value;
      logic [3:0]  gear;
      logic        bad_char;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]       data;
      bit               typed;
      frame_result_type want;
   } directed_row_type;

   localparam frame_result_type NO_RESULT = '0;

   // ignored bytes, the largest x and the smallest y, then a frame with bad bytes
   // including lowercase, the start byte inside a frame and the hex range edges
   localparam int DIRECTED_ROWS = 22;
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'hFF, 1'b0, NO_RESULT},
      '{"*",   1'b0, NO_RESULT},
      '{"7",   1'b0, NO_RESULT},
      '{"F",   1'b0, NO_RESULT},
      '{"F",   1'b0, NO_RESULT},
      '{"F",   1'b0, NO_RESULT},
      '{"8",   1'b0, NO_RESULT},
      '{"0",   1'b0, NO_RESULT},
      '{"0",   1'b0, NO_RESULT},
      '{"0",   1'b0, NO_RESULT},
      '{"F",   1'b1, '{16'h7FFF, 16'h8000, 4'hF, 1'b0}},
      '{8'h00, 1'b0, NO_RESULT},
      '{"*",   1'b0, NO_RESULT},
      '{"0",   1'b0, NO_RESULT},
      '{"a",   1'b0, NO_RESULT},
      '{"9",   1'b0, NO_RESULT},
      '{"A",   1'b0, NO_RESULT},
      '{"*",   1'b0, NO_RESULT},
      '{"G",   1'b0, NO_RESULT},
      '{"/",   1'b0, NO_RESULT},
      '{":",   1'b0, NO_RESULT},
      '{"@",   1'b1, '{16'h009A, 16'h0000, 4'h0, 1'b1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_start_char = hfjd_pkg::START_CHAR_RESET;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_x_value;
   logic [15:0] rsp_y_value;
   logic [3:0]  rsp_gear;
   logic        rsp_bad_char;

   hex_frame_joystick_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_start_char (csr_start_char),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_value    (rsp_x_value),
      .rsp_y_value    (rsp_y_value),
      .rsp_gear       (rsp_gear),
      .rsp_bad_char   (rsp_bad_char)
   );

   // decoder shadow state
   logic [7:0]  start_char_cfg;
   bit          frame_open;
   logic [3:0]  digits_taken;
   logic [15:0] x_acc;
   logic [15:0] y_acc;
   bit          frame_bad;

   frame_result_type pending_frames[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          long_hold_armed = 1'b0;
   bit          long_hold_done = 1'b0;

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // {bad, nibble}
   function automatic logic [4:0] decode_hex(input logic [7:0] b);
      if (b >= hfjd_pkg::ASCII_ZERO && b <= hfjd_pkg::ASCII_NINE) begin
         decode_hex = {1'b0, 4'(b - hfjd_pkg::ASCII_ZERO)};
      end else if (b >= hfjd_pkg::ASCII_UPPER_A && b <= hfjd_pkg::ASCII_UPPER_F) begin
         decode_hex = {1'b0, 4'(b - hfjd_pkg::HEX_ALPHA_OFFSET)};
      end else begin
         decode_hex = 5'b1_0000;
      end
   endfunction

   task automatic reset_decoder_state();
      start_char_cfg = hfjd_pkg::START_CHAR_RESET;
      frame_open = 1'b0;
      digits_taken = '0;
      x_acc = '0;
      y_acc = '0;
      frame_bad = 1'b0;
   endtask

   task automatic predict_frame_byte(input logic [7:0] b, output bit produced,
                                     output frame_result_type r);
      logic [4:0] dec;
      produced = 1'b0;
      r = NO_RESULT;
      if (!frame_open) begin
         if (b == start_char_cfg) begin
            frame_open = 1'b1;
            digits_taken = '0;
            x_acc = '0;
            y_acc = '0;
            frame_bad = 1'b0;
         end
      end else begin
         dec = decode_hex(b);
         if (dec[4]) begin
            frame_bad = 1'b1;
         end
         if (digits_taken < hfjd_pkg::X_END_POS) begin
            x_acc = {x_acc[11:0], dec[3:0]};
            digits_taken++;
         end else if (digits_taken < hfjd_pkg::GEAR_POS) begin
            y_acc = {y_acc[11:0], dec[3:0]};
            digits_taken++;
         end else begin
            produced = 1'b1;
            r = '{x_acc, y_acc, dec[3:0], frame_bad};
            frame_open = 1'b0;
            digits_taken = '0;
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed,
                            input frame_result_type want);
      bit               produced;
      frame_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_in_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_frame_byte(b, produced, predicted);
      if (typed) begin
         pending_frames.push_back(want);
      end else if (produced) begin
         pending_frames.push_back(predicted);
      end
   endtask

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(15);
      random_hex_char = (v < 10) ? 8'(hfjd_pkg::ASCII_ZERO + v) :
                                   8'(hfjd_pkg::ASCII_UPPER_A + v - 10);
   endfunction

   task automatic send_random_frame();
      int payload_len;
      if ($urandom_range(9) < 3) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
      end
      // now and then a frame is cut short and the next start byte lands as payload
      payload_len = ($urandom_range(19) == 0) ? $urandom_range(8) : 9;
      send_byte(start_char_cfg, 1'b0, NO_RESULT);
      repeat (payload_len) begin
         if ($urandom_range(99) < 88) begin
            send_byte(random_hex_char(), 1'b0, NO_RESULT);
         end else begin
            send_byte(8'($urandom_range(255)), 1'b0, NO_RESULT);
         end
      end
   endtask

   task automatic drain_frames();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_frames.size() != 0) begin
         report_mismatch($sformatf("%0d frame results never arrived", pending_frames.size()));
         pending_frames.delete();
      end
   endtask

   task automatic write_start_char(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_start_char <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      start_char_cfg = v;
   endtask

   // response side stall, with one long hold-off so the byte queue fills
   initial begin
      int hold_count;
      hold_count = 0;
      forever begin
         @(posedge clock);
         if (long_hold_armed && !long_hold_done) begin
            rsp_stall <= 1'b1;
            hold_count++;
            if (hold_count >= LONG_HOLD_CYCLES) begin
               long_hold_done = 1'b1;
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("result transfer with no frame pending");
         end else begin
            want = pending_frames.pop_front();
            if (rsp_x_value !== want.x_value) begin
               report_mismatch($sformatf("x_value %0d, expected %0d",
                  $signed(rsp_x_value), $signed(want.x_value)));
            end
            if (rsp_y_value !== want.y_value) begin
               report_mismatch($sformatf("y_value %0d, expected %0d",
                  $signed(rsp_y_value), $signed(want.y_value)));
            end
            if (rsp_gear !== want.gear) begin
               report_mismatch($sformatf("gear %0d, expected %0d", rsp_gear, want.gear));
            end
            if (rsp_bad_char !== want.bad_char) begin
               report_mismatch($sformatf("bad_char %0b, expected %0b",
                  rsp_bad_char, want.bad_char));
            end
         end
      end
   end

   initial begin
      logic [7:0] phase_start_char [PHASE_COUNT];
      int         phase_idle [PHASE_COUNT];
      int         phase_stall [PHASE_COUNT];
      phase_start_char = '{hfjd_pkg::START_CHAR_RESET, 8'hFF, 8'h00, "5"};
      phase_idle = '{0, 47, 0, 34};
      phase_stall = '{0, 0, 47, 34};
      reset_decoder_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      end
      drain_frames();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         write_start_char(phase_start_char[p]);
         if (p == 0) begin
            long_hold_armed = 1'b1;
         end
         repeat (FRAMES_PER_PHASE) send_random_frame();
         drain_frames();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hfjd_pkg.sv
hw/rtl/hfjd_queue.sv
hw/rtl/hfjd_front.sv
hw/rtl/hfjd_back.sv
hw/rtl/hex_frame_joystick_decoder.sv
hw/rtl/hfjd_checker.sv
test/hex_frame_joystick_decoder_test.sv
